// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, ignored while reset is asserted.
`define STS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define STS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/sts_pkg.sv -----
// Package for the sorted table search block: defaults, command codes, sequencer states.
package sts_pkg;

    // Parameter defaults
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_WIDTH_DEF   = 32;

    // Command codes
    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_ANY   = 3'd1;
    localparam logic [2:0] CMD_FIRST = 3'd2;
    localparam logic [2:0] CMD_LAST  = 3'd3;
    localparam logic [2:0] CMD_COUNT = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/sorted_table_binary_search.sv -----
// Sorted table search: table memory, entry count register and bisection sequencer.
//
// A transfer is taken when start is high and busy is low. A write command (0) stores
// value at entry_index and never raises busy. A search command (1 any, 2 first,
// 3 last, 4 count) bisects entries 0..entry_count-1; each bisection step reads the
// midpoint entry from the table in ST_READ and compares it with the key in ST_CMP,
// and count mode runs two passes. The result then shows on o_found, o_position and
// o_occurrences with o_strobe high for exactly one cycle, registered after the
// sequencer passes through ST_DONE; the receiver must take it then.
// busy is already low in the strobe cycle, so the next command may start there.
// Commands 5 to 7 are taken and dropped. Entry count writes above TABLE_DEPTH
// saturate; write it only while the block is idle.
module sorted_table_binary_search
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    localparam int IDX_W      = $clog2(TABLE_DEPTH),
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_command,
    input  logic [IDX_W-1:0]            i_entry_index,
    input  logic signed [KEY_WIDTH-1:0] i_value,
    input  logic                        i_cfg_we,
    input  logic [CNT_W-1:0]            i_cfg_wdata,
    output logic                        o_strobe,
    output logic                        o_found,
    output logic [IDX_W-1:0]            o_position,
    output logic [CNT_W-1:0]            o_occurrences
);

    // Table memory
    logic signed [KEY_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic signed [KEY_WIDTH-1:0] r_rdata;

    // Control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_entry_count;
    logic               r_strobe, n_strobe;
    logic               r_pass, n_pass;
    logic               r_hit, n_hit;
    logic               r_first_hit, n_first_hit;

    // Payload state
    logic [2:0]                  r_cmd, n_cmd;
    logic signed [KEY_WIDTH-1:0] r_key, n_key;
    logic [CNT_W-1:0]            r_lo, n_lo;
    logic [CNT_W-1:0]            r_hi, n_hi;
    logic [IDX_W-1:0]            r_mid, n_mid;
    logic [IDX_W-1:0]            r_pos, n_pos;
    logic [IDX_W-1:0]            r_first_pos, n_first_pos;
    logic                        r_found, n_found;
    logic [IDX_W-1:0]            r_position, n_position;
    logic [CNT_W-1:0]            r_occ, n_occ;

    logic             accept;
    logic             mem_we;
    logic             rd_en;
    logic             range_ok;
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] mid_full;
    logic             key_eq;
    logic             key_lt;
    logic             go_left_on_eq;
    logic             last_ok;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign mem_we = accept && (i_command == CMD_WRITE)
                    && ((IDX_W+1)'(i_entry_index) < (IDX_W+1)'(TABLE_DEPTH));

    // Midpoint of the live range [lo, hi): lo + (hi-1-lo)/2
    assign range_ok = (r_lo < r_hi);
    assign span     = r_hi - r_lo - CNT_W'(1);
    assign mid_full = r_lo + (span >> 1);
    assign rd_en    = (r_state == ST_READ) && range_ok;

    // Shared compare unit
    assign key_eq        = (r_key == r_rdata);
    assign key_lt        = (r_key < r_rdata);
    assign go_left_on_eq = (r_cmd == CMD_FIRST) || ((r_cmd == CMD_COUNT) && !r_pass);
    assign last_ok       = r_first_hit && r_hit && (r_pos >= r_first_pos);

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_entry_index] <= i_value;
        end
        if (rd_en) begin
            r_rdata <= r_mem[mid_full[IDX_W-1:0]];
        end
    end

    // Sequencer next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_strobe    = 1'b0;
        n_pass      = r_pass;
        n_hit       = r_hit;
        n_first_hit = r_first_hit;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_pos       = r_pos;
        n_first_pos = r_first_pos;
        n_found     = r_found;
        n_position  = r_position;
        n_occ       = r_occ;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_command == CMD_ANY || i_command == CMD_FIRST
                               || i_command == CMD_LAST || i_command == CMD_COUNT)) begin
                    n_state = ST_READ;
                    n_cmd   = i_command;
                    n_key   = i_value;
                    n_lo    = '0;
                    n_hi    = r_entry_count;
                    n_hit   = 1'b0;
                    n_pass  = 1'b0;
                end
            end
            ST_READ: begin
                if (range_ok) begin
                    n_mid   = mid_full[IDX_W-1:0];
                    n_state = ST_CMP;
                end else if (r_cmd == CMD_COUNT && !r_pass) begin
                    // first-occurrence pass done, start the last-occurrence pass
                    n_first_hit = r_hit;
                    n_first_pos = r_pos;
                    n_pass      = 1'b1;
                    n_hit       = 1'b0;
                    n_lo        = '0;
                    n_hi        = r_entry_count;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_CMP: begin
                n_state = ST_READ;
                if (key_eq) begin
                    n_hit = 1'b1;
                    n_pos = r_mid;
                    if (r_cmd == CMD_ANY) begin
                        n_state = ST_DONE;
                    end else if (go_left_on_eq) begin
                        n_hi = CNT_W'(r_mid);
                    end else begin
                        n_lo = CNT_W'(r_mid) + CNT_W'(1);
                    end
                end else if (key_lt) begin
                    n_hi = CNT_W'(r_mid);
                end else begin
                    n_lo = CNT_W'(r_mid) + CNT_W'(1);
                end
            end
            ST_DONE: begin
                n_state  = ST_IDLE;
                n_strobe = 1'b1;
                if (r_cmd == CMD_COUNT) begin
                    n_found    = r_first_hit;
                    n_position = r_first_hit ? r_first_pos : '0;
                    n_occ      = last_ok ? (CNT_W'(r_pos) - CNT_W'(r_first_pos) + CNT_W'(1))
                                         : '0;
                end else begin
                    n_found    = r_hit;
                    n_position = r_hit ? r_pos : '0;
                    n_occ      = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_strobe      <= 1'b0;
            r_entry_count <= '0;
            r_pass        <= 1'b0;
            r_hit         <= 1'b0;
            r_first_hit   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_strobe    <= n_strobe;
            r_pass      <= n_pass;
            r_hit       <= n_hit;
            r_first_hit <= n_first_hit;
            if (i_cfg_we) begin
                r_entry_count <= (i_cfg_wdata > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                                     : i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_pos       <= n_pos;
        r_first_pos <= n_first_pos;
        r_found     <= n_found;
        r_position  <= n_position;
        r_occ       <= n_occ;
    end

    assign o_strobe      = r_strobe;
    assign o_found       = r_found;
    assign o_position    = r_position;
    assign o_occurrences = r_occ;

endmodule

// ----- rtl/core/sts_checker.sv -----
// Port-level checker for the sorted table search block, with its bind.
`include "assert_macros.svh"

module sts_checker
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int IDX_W      = $clog2(TABLE_DEPTH),
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [2:0]       i_command,
    input logic             o_strobe,
    input logic             o_found,
    input logic [IDX_W-1:0] o_position,
    input logic [CNT_W-1:0] o_occurrences
);

    logic search_xfer;
    logic write_xfer;
    logic miss_clean;

    // Transfer classes seen at the input
    assign search_xfer = start && !busy && (i_command == CMD_ANY || i_command == CMD_FIRST
                         || i_command == CMD_LAST || i_command == CMD_COUNT);
    assign write_xfer  = start && !busy && (i_command == CMD_WRITE);
    assign miss_clean  = (o_position == '0) && (o_occurrences == '0);

    // Reset leaves the block idle with no result pending
    `STS_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !(o_strobe || busy), "active after reset")

    // A result lasts a single cycle
    `STS_ASSERT(a_strobe_pulse, i_clk, i_rst_n, o_strobe |=> !o_strobe, "strobe too long")

    // A search transfer occupies the block
    `STS_ASSERT(a_search_busy, i_clk, i_rst_n, search_xfer |=> busy, "search did not raise busy")

    // A table write completes at once
    `STS_ASSERT(a_write_free, i_clk, i_rst_n, write_xfer |=> (!busy && !o_strobe), "write busy")

    // A miss reports zero position and zero count
    `STS_ASSERT(a_miss_zero, i_clk, i_rst_n, (o_strobe && !o_found) |-> miss_clean, "nonzero miss")

endmodule

bind sorted_table_binary_search sts_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_sts_checker (.*);
